/* hw/rtl/queue_with_middle_insert_core_defines.svh */
// Assertion macros for the queue core checker.
`ifndef QUEUE_WITH_MIDDLE_INSERT_CORE_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_INSERT_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define QWMI_CHECK_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define QWMI_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/qwmi_pkg.sv */
package qwmi_pkg;

   // Fixed field widths
   localparam int OPCODE_W  = 2;
   localparam int STATUS_W  = 2;
   localparam int IO_DATA_W = 32;
   localparam int OCC_W     = 11;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OPC_PUSH   = 2'd0;
   localparam logic [OPCODE_W-1:0] OPC_POP    = 2'd1;
   localparam logic [OPCODE_W-1:0] OPC_INSERT = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_STORED    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_POPPED    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

   // What one accepted item turns into
   typedef enum logic [2:0] {
      OPK_NOP,
      OPK_EMPTY,
      OPK_FULL,
      OPK_PUSH,
      OPK_INSERT,
      OPK_POP
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LINK,
      ST_COMMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic        load;
      logic        mem_read;
      logic        link_step;
      logic        commit;
      op_kind_type kind;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;
   } dp_stat_type;

endpackage

/* hw/rtl/qwmi_ctrl.sv */
module qwmi_ctrl
   import qwmi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  dp_stat_type         stat,
   output ctl_cmd_type         cmd
);

   state_type   state_ff, state_in;
   op_kind_type kind_ff, kind_in;
   op_kind_type dec_kind;

   // Hold state and the decoded operation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= OPK_NOP;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // Classify the incoming item against the current fill level
   always_comb begin
      case (req_opcode)
         OPC_PUSH:   dec_kind = stat.full  ? OPK_FULL  : OPK_PUSH;
         OPC_INSERT: dec_kind = stat.full  ? OPK_FULL  : OPK_INSERT;
         OPC_POP:    dec_kind = stat.empty ? OPK_EMPTY : OPK_POP;
         default:    dec_kind = OPK_NOP;
      endcase
   end

   // Sequence one item: accept and read, link step (push, insert, pop only), commit
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.mem_read  = 1'b0;
      cmd.link_step = 1'b0;
      cmd.commit    = 1'b0;
      cmd.kind      = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.kind  = dec_kind;
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.mem_read = 1'b1;
               kind_in      = dec_kind;
               if (dec_kind == OPK_PUSH || dec_kind == OPK_INSERT ||
                   dec_kind == OPK_POP) begin
                  state_in = ST_LINK;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_LINK: begin
            cmd.link_step = 1'b1;
            state_in      = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/qwmi_dp.sv */
module qwmi_dp
   import qwmi_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ctl_cmd_type                 cmd,
   output dp_stat_type                 stat,
   input  logic signed [IO_DATA_W-1:0] req_data_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic signed [IO_DATA_W-1:0] rsp_data_out,
   output logic [OCC_W-1:0]            rsp_occupancy
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Memories
   logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
   logic [IDX_W-1:0]      link_mem  [CAPACITY];
   logic [IDX_W-1:0]      free_mem  [CAPACITY];

   // Control registers
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] free_top_ff, free_top_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [DATA_WIDTH-1:0]       item_ff;
   logic [IDX_W-1:0]            x_ff, x_in;
   logic [IDX_W-1:0]            link_a_ff, link_a_in;
   logic [IDX_W-1:0]            link_rd_ff;
   logic [IDX_W-1:0]            free_rd_ff;
   logic [DATA_WIDTH-1:0]       value_rd_ff;
   logic [STATUS_W-1:0]         status_ff, status_in;
   logic signed [IO_DATA_W-1:0] data_out_ff, data_out_in;
   logic [OCC_W-1:0]            occ_ff, occ_in;

   // Memory port controls
   logic                  value_we;
   logic [IDX_W-1:0]      value_waddr;
   logic                  link_we;
   logic [IDX_W-1:0]      link_waddr;
   logic [IDX_W-1:0]      link_wdata;
   logic                  link_re;
   logic [IDX_W-1:0]      link_raddr;
   logic                  free_we;
   logic [IDX_W-1:0]      free_raddr;
   logic [CNT_W-1:0]      free_top_m1;

   logic [63:0]           in_ext;
   logic [63:0]           pop_ext;
   logic [IDX_W-1:0]      x_sel;
   logic                  is_store;
   logic                  is_empty;
   logic                  is_even;

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff >= CNT_W'(CAPACITY));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign is_empty    = stat.empty;
   assign is_even     = !count_ff[0];
   assign is_store    = (cmd.kind == OPK_PUSH) || (cmd.kind == OPK_INSERT);
   assign free_top_m1 = free_top_ff - 1'b1;
   assign free_raddr  = free_top_m1[IDX_W-1:0];
   assign x_sel       = (free_top_ff != '0) ? free_rd_ff : fresh_ff[IDX_W-1:0];
   assign in_ext      = {32'b0, req_data_in};
   assign pop_ext     = {{(64 - DATA_WIDTH){value_rd_ff[DATA_WIDTH-1]}}, value_rd_ff};

   // Read ports; the link read address depends on the operation
   always_comb begin
      link_re    = cmd.mem_read || (cmd.link_step && cmd.kind == OPK_POP);
      link_raddr = mid_ff;
      if (cmd.mem_read && cmd.kind == OPK_POP) begin
         link_raddr = head_ff;
      end
   end

   // Compute next pointers, memory writes and the result
   always_comb begin
      count_in     = count_ff;
      free_top_in  = free_top_ff;
      fresh_in     = fresh_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      mid_in       = mid_ff;
      x_in         = x_ff;
      link_a_in    = link_a_ff;
      status_in    = status_ff;
      data_out_in  = data_out_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      value_we     = 1'b0;
      value_waddr  = x_sel;
      link_we      = 1'b0;
      link_waddr   = x_sel;
      link_wdata   = '0;
      free_we      = 1'b0;

      // Link step: allocate or release a slot, write the new entry
      if (cmd.link_step) begin
         link_a_in = link_rd_ff;
         if (is_store) begin
            x_in     = x_sel;
            value_we = 1'b1;
            link_we  = 1'b1;
            if (cmd.kind == OPK_INSERT && !is_empty) begin
               link_wdata = link_rd_ff;
            end
            if (free_top_ff != '0) begin
               free_top_in = free_top_m1;
            end else begin
               fresh_in = fresh_ff + 1'b1;
            end
         end else if (cmd.kind == OPK_POP) begin
            if (free_top_ff < CNT_W'(CAPACITY)) begin
               free_we     = 1'b1;
               free_top_in = free_top_ff + 1'b1;
            end
         end
      end

      // Commit: splice the list, move pointers, load the result
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         data_out_in  = '0;
         status_in    = STAT_STORED;
         case (cmd.kind)
            OPK_PUSH, OPK_INSERT: begin
               count_in = count_ff + 1'b1;
               if (is_empty) begin
                  head_in = x_ff;
                  tail_in = x_ff;
                  mid_in  = x_ff;
               end else if (cmd.kind == OPK_PUSH) begin
                  link_we    = 1'b1;
                  link_waddr = tail_ff;
                  link_wdata = x_ff;
                  tail_in    = x_ff;
                  if (is_even) begin
                     mid_in = link_a_ff;
                  end
               end else begin
                  link_we    = 1'b1;
                  link_waddr = mid_ff;
                  link_wdata = x_ff;
                  if (mid_ff == tail_ff) begin
                     tail_in = x_ff;
                  end
                  if (is_even) begin
                     mid_in = x_ff;
                  end
               end
            end
            OPK_POP: begin
               status_in   = STAT_POPPED;
               data_out_in = pop_ext[IO_DATA_W-1:0];
               count_in    = count_ff - 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
                  mid_in  = '0;
               end else begin
                  head_in = link_a_ff;
                  if (is_even) begin
                     mid_in = link_rd_ff;
                  end
               end
            end
            OPK_EMPTY: status_in = STAT_POP_EMPTY;
            OPK_FULL:  status_in = STAT_FULL;
            default:   status_in = STAT_STORED;
         endcase
         occ_in = OCC_W'(count_in);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         free_top_ff  <= '0;
         fresh_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         mid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         free_top_ff  <= free_top_in;
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         mid_ff       <= mid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= in_ext[DATA_WIDTH-1:0];
      end
      x_ff        <= x_in;
      link_a_ff   <= link_a_in;
      status_ff   <= status_in;
      data_out_ff <= data_out_in;
      occ_ff      <= occ_in;
   end

   // Value memory: read the head, write the new entry
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_waddr] <= item_ff;
      end
      if (cmd.mem_read) begin
         value_rd_ff <= value_mem[head_ff];
      end
   end

   // Link memory
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   // Free slot stack
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_top_ff[IDX_W-1:0]] <= head_ff;
      end
      if (cmd.mem_read) begin
         free_rd_ff <= free_mem[free_raddr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_data_out  = data_out_ff;
   assign rsp_occupancy = occ_ff;

endmodule

/* hw/rtl/queue_with_middle_insert_core.sv */
// Bounded queue of CAPACITY values held as a linked list, with push at the
// back, pop from the front and insert just after the middle entry. Each item
// returns one result: a status code, the popped value (zero unless popped)
// and the occupancy after the operation. Push, pop and insert go from
// acceptance to result through accept with memory reads, link step and
// commit; the link step exists as the link memory serves one read and one
// write a cycle: a push or insert writes the new entry and then splices it
// into the list, and a pop reads the successor of the head and then that
// of the middle. A rejected operation or an unknown opcode skips the link
// step. One item is in flight at a time; a finished result waits in an
// output register, and a commit stalls only while that register is still
// full. No clearing pass follows reset.
module queue_with_middle_insert_core
   import qwmi_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [OPCODE_W-1:0]         req_opcode,
   input  logic signed [IO_DATA_W-1:0] req_data_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic signed [IO_DATA_W-1:0] rsp_data_out,
   output logic [OCC_W-1:0]            rsp_occupancy
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // Sequence each item
   qwmi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the list, the free slots and the result
   qwmi_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data_out  (rsp_data_out),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

/* hw/rtl/qwmi_checker.sv */
`include "queue_with_middle_insert_core_defines.svh"

module qwmi_checker
   import qwmi_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [OPCODE_W-1:0]         req_opcode,
   input logic signed [IO_DATA_W-1:0] req_data_in,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [STATUS_W-1:0]         rsp_status,
   input logic signed [IO_DATA_W-1:0] rsp_data_out,
   input logic [OCC_W-1:0]            rsp_occupancy
);

   logic req_seen;

   // Track that an item was taken in
   assign req_seen = req_valid && req_ready;

   // One item at a time: no acceptance right after another
   `QWMI_CHECK_NEXT(a_one_in_flight, clock, reset, req_seen, !req_ready, "item accepted back to back")

   // A waiting input item holds
   `QWMI_CHECK_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_opcode) && $stable(req_data_in), "waiting item changed")

   // A stalled result holds
   `QWMI_CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data_out) && $stable(rsp_occupancy), "stalled result changed")

   // Only a pop carries data
   `QWMI_CHECK_SAME(a_data_zero, clock, reset, rsp_valid && (rsp_status != STAT_POPPED), rsp_data_out == '0, "data without a pop")

   // A pop on empty leaves the queue empty
   `QWMI_CHECK_SAME(a_empty_occ, clock, reset, rsp_valid && (rsp_status == STAT_POP_EMPTY), rsp_occupancy == '0, "empty pop with entries held")

endmodule

bind queue_with_middle_insert_core qwmi_checker u_qwmi_checker (.*);

/* verif/tb_queue_with_middle_insert_core.sv */
`timescale 1ns / 100ps

module tb_queue_with_middle_insert_core;
   import qwmi_pkg::*;

   localparam int QUEUE_DEPTH = 1024;
   localparam int SEGMENT_ITEMS = 150;
   localparam int RSP_LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [OPCODE_W-1:0] OPC_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0]         status;
      logic signed [IO_DATA_W-1:0] data;
      logic [OCC_W-1:0]            occupancy;
   } queue_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [OPCODE_W-1:0]         req_opcode = OPC_PUSH;
   logic signed [IO_DATA_W-1:0] req_data_in = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [IO_DATA_W-1:0] rsp_data_out;
   logic [OCC_W-1:0]            rsp_occupancy;

   // predicted queue contents, front first, and results still to come
   logic signed [IO_DATA_W-1:0] held_values[$];
   queue_result_type            expected_results[$];

   int error_count = 0;
   bit quiet_traffic = 1'b0;
   int rsp_hold_request = 0;
   int rsp_stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   queue_with_middle_insert_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data_out  (rsp_data_out),
      .rsp_occupancy (rsp_occupancy)
   );

   // Mostly short gaps, now and then a long one; none in quiet stretches
   function automatic int pick_gap();
      int r;
      if (quiet_traffic) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 2);
      if (r < 96) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic signed [IO_DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_opcode(input int add_pct, input int pop_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < add_pct) return ($urandom_range(0, 1) == 0) ? OPC_PUSH : OPC_INSERT;
      if (r < add_pct + pop_pct) return OPC_POP;
      return OPC_UNUSED;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Apply one operation to the predicted queue and queue up its result
   function automatic void predict_queue_op(input logic [OPCODE_W-1:0] opc,
                                            input logic signed [IO_DATA_W-1:0] val);
      queue_result_type res;
      int at;
      res.status = STAT_STORED;
      res.data = '0;
      case (opc)
         OPC_PUSH, OPC_INSERT: begin
            if (held_values.size() >= QUEUE_DEPTH) begin
               res.status = STAT_FULL;
            end else if (opc == OPC_PUSH) begin
               held_values.push_back(val);
            end else begin
               // land just behind the middle entry, position ceil(n/2)+1
               at = (held_values.size() + 1) / 2;
               held_values.insert(at, val);
            end
         end
         OPC_POP: begin
            if (held_values.size() == 0) begin
               res.status = STAT_POP_EMPTY;
            end else begin
               res.status = STAT_POPPED;
               res.data = held_values.pop_front();
            end
         end
         default: ;
      endcase
      res.occupancy = OCC_W'(held_values.size());
      expected_results.push_back(res);
   endfunction

   // Offer one item, hold it until accepted, then predict its result
   task automatic send_item(input logic [OPCODE_W-1:0] opc,
                            input logic signed [IO_DATA_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opc;
      req_data_in <= val;
      do @(posedge clock); while (!req_ready);
      predict_queue_op(opc, val);
   endtask

   // Check each result item against the oldest prediction, then pick ready
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status=%0d data=%0d occ=%0d",
                                         rsp_status, rsp_data_out, rsp_occupancy));
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_status, want.status));
               if (rsp_data_out !== want.data)
                  report_mismatch($sformatf("data_out %0d, want %0d",
                                            rsp_data_out, want.data));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, want %0d",
                                            rsp_occupancy, want.occupancy));
            end
         end
         // take up a long hold-off when one is asked for
         if (rsp_hold_request > 0) begin
            rsp_stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_traffic && $urandom_range(0, 3) == 0) begin
            rsp_stall_left = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Empty-queue cases, value extremes and the insert position at small sizes
   task automatic test_directed();
      send_item(OPC_POP, 32'h0000_0000);
      send_item(OPC_UNUSED, 32'h1234_5678);
      send_item(OPC_INSERT, 32'h7fff_ffff);
      send_item(OPC_INSERT, 32'h8000_0000);
      send_item(OPC_PUSH, 32'h0000_0000);
      send_item(OPC_INSERT, 32'hffff_ffff);
      send_item(OPC_INSERT, 32'h0000_0005);
      send_item(OPC_PUSH, 32'h5555_5555);
      send_item(OPC_UNUSED, 32'hffff_ffff);
      repeat (6) send_item(OPC_POP, 32'hffff_ffff);
      send_item(OPC_POP, 32'h0000_0000);
      send_item(OPC_PUSH, 32'haaaa_aaaa);
      send_item(OPC_POP, 32'h0000_0000);
      send_item(OPC_PUSH, 32'h0000_0001);
      send_item(OPC_INSERT, 32'h0000_0002);
      send_item(OPC_POP, 32'h0000_0000);
      send_item(OPC_POP, 32'h0000_0000);
   endtask

   // Mixed traffic with more adds than pops, so the queue slowly grows
   task automatic test_random_mix(input int count);
      for (int k = 0; k < count; k++) begin
         quiet_traffic = ((k / SEGMENT_ITEMS) % 3) == 1;
         send_item(pick_opcode(60, 35), pick_value());
      end
      quiet_traffic = 1'b0;
   endtask

   // Grow to capacity under backpressure, then probe the full queue
   task automatic test_fill_to_capacity();
      int k;
      k = 0;
      rsp_hold_request = RSP_LONG_HOLD;
      while (held_values.size() < QUEUE_DEPTH) begin
         quiet_traffic = ((k / SEGMENT_ITEMS) % 3) != 2;
         send_item(pick_opcode(90, 8), pick_value());
         k++;
      end
      quiet_traffic = 1'b0;
      send_item(OPC_PUSH, 32'h7fff_ffff);
      send_item(OPC_INSERT, 32'h8000_0000);
      send_item(OPC_UNUSED, 32'h0000_0000);
      send_item(OPC_POP, 32'h0000_0000);
      send_item(OPC_INSERT, 32'h8000_0000);
      send_item(OPC_INSERT, 32'h7fff_ffff);
      send_item(OPC_POP, 32'h0000_0000);
      send_item(OPC_PUSH, 32'hffff_ffff);
      send_item(OPC_PUSH, 32'h0000_0000);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(400);
      test_fill_to_capacity();
      req_valid <= 1'b0;
      // drain outstanding results, then watch for strays
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
